// ----- rtl/bole_pkg.sv -----
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and constants of the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

	localparam int CAPACITY    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int READ_LIMIT  = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

	localparam int DATA_W = 32;
	localparam int POS_W  = 8;
	localparam int IDX_W  = 5;
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	// Width for compares that mix counts, positions and pointers plus a small offset.
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		OP_INS_HEAD = 2'd0,
		OP_INS_POS  = 2'd1,
		OP_DELETE   = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SHIFT,
		S_INS_PLACE,
		S_DEL_SEARCH,
		S_DEL_SHIFT,
		S_READOUT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic                     rd_en;
		logic [ADDR_W-1:0]        rd_addr;
		logic                     wr_en;
		logic [ADDR_W-1:0]        wr_addr;
		logic signed [DATA_W-1:0] wr_data;
	} ram_req_t;

endpackage

// ----- rtl/bole_if.sv -----
// ----------------------------------------------------------------------------
// bole_if
// Valid/ready channels of the bounded ordered list engine.
// ----------------------------------------------------------------------------
interface bole_cmd_if;
	import bole_pkg::*;

	logic                     valid;
	logic                     ready;
	op_t                      operation;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, operation, value, position, input ready);
	modport sink   (input valid, operation, value, position, output ready);
endinterface

interface bole_rsp_if;
	import bole_pkg::*;

	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DATA_W-1:0] item_value;
	logic [IDX_W-1:0]         item_index;
	logic                     last;

	modport source (output valid, status, item_value, item_index, last, input ready);
	modport sink   (input valid, status, item_value, item_index, last, output ready);
endinterface

// ----- rtl/bole_ram.sv -----
// ----------------------------------------------------------------------------
// bole_ram
// Generic single-clock RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module bole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]                              wr_data,
	input  logic                                          rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	output logic [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// Read data holds until the next read.
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/bole_ctrl.sv -----
// ----------------------------------------------------------------------------
// bole_ctrl
// Sequencer of the list: searches and shifts the list memory one entry a cycle
// and holds the result register.
// ----------------------------------------------------------------------------
module bole_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	bole_cmd_if.sink                            cmd,
	bole_rsp_if.source                          rsp,
	output bole_pkg::ram_req_t                  ram_req,
	input  logic signed [bole_pkg::DATA_W-1:0]  ram_rd_data
);
	import bole_pkg::*;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [ADDR_W-1:0]        ptr_q, ptr_d;
	logic [ADDR_W-1:0]        slot_q, slot_d;
	logic signed [DATA_W-1:0] value_q, value_d;

	status_t                  res_status_q, res_status_d;
	logic signed [DATA_W-1:0] res_value_q, res_value_d;
	logic [IDX_W-1:0]         res_index_q, res_index_d;

	logic                     out_valid_q, out_valid_d;
	status_t                  out_status_q, out_status_d;
	logic signed [DATA_W-1:0] out_value_q, out_value_d;
	logic [IDX_W-1:0]         out_index_q, out_index_d;
	logic                     out_last_q, out_last_d;

	logic             cmd_fire;
	logic             out_free;
	logic             is_full;
	logic             pos_bad;
	logic [CMP_W-1:0] count_x;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] ptr_x;
	logic [CMP_W-1:0] slot_x;
	logic [ADDR_W-1:0] ins_slot;
	logic             read_final;

	assign cmd.ready   = (state_q == S_IDLE);
	assign cmd_fire    = cmd.valid && cmd.ready;
	assign out_free    = !out_valid_q || rsp.ready;

	assign count_x  = CMP_W'(count_q);
	assign pos_x    = CMP_W'(cmd.position);
	assign ptr_x    = CMP_W'(ptr_q);
	assign slot_x   = CMP_W'(slot_q);
	assign is_full  = (count_x >= CMP_W'(CAPACITY));
	// Position 1 on an empty list is the only way past the count.
	assign pos_bad  = (pos_x == '0) ||
		((pos_x > count_x) && !((pos_x == CMP_W'(1)) && (count_x == '0)));
	assign ins_slot = (cmd.operation == OP_INS_POS) ?
		ADDR_W'(pos_x - CMP_W'(1)) : '0;
	assign read_final = ((ptr_x + CMP_W'(1)) == count_x) ||
		((ptr_x + CMP_W'(1)) == CMP_W'(READ_LIMIT));

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.item_value = out_value_q;
	assign rsp.item_index = out_index_q;
	assign rsp.last       = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q        <= ptr_d;
		slot_q       <= slot_d;
		value_q      <= value_d;
		res_status_q <= res_status_d;
		res_value_q  <= res_value_d;
		res_index_q  <= res_index_d;
		out_status_q <= out_status_d;
		out_value_q  <= out_value_d;
		out_index_q  <= out_index_d;
		out_last_q   <= out_last_d;
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		slot_d       = slot_q;
		value_d      = value_q;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		res_index_d  = res_index_q;
		out_valid_d  = out_valid_q && !rsp.ready;
		out_status_d = out_status_q;
		out_value_d  = out_value_q;
		out_index_d  = out_index_q;
		out_last_d   = out_last_q;
		ram_req      = '0;

		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					value_d      = cmd.value;
					res_value_d  = '0;
					res_index_d  = '0;
					res_status_d = ST_OK;
					case (cmd.operation)
						OP_INS_HEAD, OP_INS_POS: begin
							slot_d = ins_slot;
							if (is_full) begin
								res_status_d = ST_FULL;
								state_d      = S_RESP;
							end else if (cmd.operation == OP_INS_POS && pos_bad) begin
								res_status_d = ST_BAD_POS;
								state_d      = S_RESP;
							end else if (count_x > CMP_W'(ins_slot)) begin
								// Move the tail up one entry at a time, from the end.
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = ADDR_W'(count_x - CMP_W'(1));
								ptr_d           = ADDR_W'(count_x);
								state_d         = S_INS_SHIFT;
							end else begin
								state_d = S_INS_PLACE;
							end
						end
						OP_DELETE, OP_READ: begin
							if (count_q == '0) begin
								res_status_d = ST_EMPTY;
								state_d      = S_RESP;
							end else begin
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = '0;
								ptr_d           = '0;
								state_d         = (cmd.operation == OP_DELETE) ?
									S_DEL_SEARCH : S_READOUT;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end

			S_INS_SHIFT: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = ptr_q;
				ram_req.wr_data = ram_rd_data;
				if (ptr_x > slot_x + CMP_W'(1)) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = ADDR_W'(ptr_x - CMP_W'(2));
					ptr_d           = ADDR_W'(ptr_x - CMP_W'(1));
				end else begin
					state_d = S_INS_PLACE;
				end
			end

			S_INS_PLACE: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = slot_q;
				ram_req.wr_data = value_q;
				count_d         = count_q + CNT_W'(1);
				state_d         = S_RESP;
			end

			S_DEL_SEARCH: begin
				if (ram_rd_data == value_q) begin
					res_value_d = ram_rd_data;
					res_index_d = IDX_W'(ptr_x + CMP_W'(1));
					if (ptr_x + CMP_W'(1) < count_x) begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = ADDR_W'(ptr_x + CMP_W'(1));
						state_d         = S_DEL_SHIFT;
					end else begin
						count_d = count_q - CNT_W'(1);
						state_d = S_RESP;
					end
				end else if (ptr_x + CMP_W'(1) < count_x) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = ADDR_W'(ptr_x + CMP_W'(1));
					ptr_d           = ADDR_W'(ptr_x + CMP_W'(1));
				end else begin
					res_status_d = ST_NOT_FOUND;
					state_d      = S_RESP;
				end
			end

			S_DEL_SHIFT: begin
				// Close the gap: entry ptr takes the entry above it.
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = ptr_q;
				ram_req.wr_data = ram_rd_data;
				if (ptr_x + CMP_W'(2) < count_x) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = ADDR_W'(ptr_x + CMP_W'(2));
					ptr_d           = ADDR_W'(ptr_x + CMP_W'(1));
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = S_RESP;
				end
			end

			S_READOUT: begin
				// The read data holds while the result register is occupied.
				if (out_free) begin
					out_valid_d  = 1'b1;
					out_status_d = ST_OK;
					out_value_d  = ram_rd_data;
					out_index_d  = IDX_W'(ptr_x + CMP_W'(1));
					out_last_d   = read_final;
					if (read_final) begin
						state_d = S_IDLE;
					end else begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = ADDR_W'(ptr_x + CMP_W'(1));
						ptr_d           = ADDR_W'(ptr_x + CMP_W'(1));
					end
				end
			end

			S_RESP: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					out_status_d = res_status_q;
					out_value_d  = res_value_q;
					out_index_d  = res_index_q;
					out_last_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
		else $error("list memory read and written at the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("element count exceeds capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (state_q != S_IDLE))
		else $error("transaction accepted without any work");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) ||
		(count_q == $past(count_q) - CNT_W'(1)))
		else $error("element count moved by more than one");

endmodule

// ----- rtl/bounded_ordered_list_engine.sv -----
// Bounded ordered list engine. Holds an ordered list of up to CAPACITY signed
// 32-bit values in a single-port-read, single-port-write memory and takes one
// command transaction at a time. An insert moves the tail up one entry per
// cycle, then writes the new value and presents its response.
// A delete scans one entry per cycle until the key is found, then moves the rest
// of the list down one entry per cycle. A read-out gives one response
// transaction per element, one per cycle while the sink is ready. All of these
// rates follow from the one read and one write the list memory offers per
// cycle. Every command ends with exactly one response marked last; a new
// command is taken as soon as the previous one has loaded its final response,
// even while that response still waits for the sink.
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Top level: list memory and the sequencer that searches and shifts it.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine (
	input  logic       clk,
	input  logic       arst_n,
	bole_cmd_if.sink   cmd,
	bole_rsp_if.source rsp
);
	import bole_pkg::*;

	ram_req_t                 ram_req;
	logic signed [DATA_W-1:0] ram_rd_data;

	bole_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.ram_req     (ram_req),
		.ram_rd_data (ram_rd_data)
	);

	bole_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_list_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

// ----- dv/list_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// Watches the command and response channels of the ordered list engine. It
// keeps its own copy of the list, works out the responses that each accepted
// command must give, and compares every response transaction with them.
// ----------------------------------------------------------------------------
module list_checker (
	input  logic clk,
	input  logic arst_n,
	bole_cmd_if  cmd,
	bole_rsp_if  rsp,
	output int   error_count,
	output int   pending,
	output int   results_checked
);
	import bole_pkg::*;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] item_value;
		logic [IDX_W-1:0]         item_index;
		logic                     last;
	} rsp_item_t;

	logic signed [DATA_W-1:0] shadow_list[$];
	rsp_item_t                expected_rsp_q[$];
	rsp_item_t                oldest;

	function automatic void push_rsp(status_t status, logic signed [DATA_W-1:0] item_value,
			int item_index, logic last);
		rsp_item_t item;
		item.status     = status;
		item.item_value = item_value;
		item.item_index = item_index[IDX_W-1:0];
		item.last       = last;
		expected_rsp_q.push_back(item);
	endfunction

	function automatic void predict_command(op_t op, logic signed [DATA_W-1:0] value,
			logic [POS_W-1:0] position);
		int count;
		int hit;
		int n;
		count = shadow_list.size();
		hit   = -1;
		case (op)
			OP_INS_HEAD, OP_INS_POS: begin
				// A full list is reported before the position is looked at.
				if (count >= CAPACITY)
					push_rsp(ST_FULL, '0, 0, 1'b1);
				else if (op == OP_INS_POS && (position == 0 ||
						(position > count && !(position == 1 && count == 0))))
					push_rsp(ST_BAD_POS, '0, 0, 1'b1);
				else begin
					shadow_list.insert((op == OP_INS_HEAD) ? 0 : int'(position) - 1, value);
					push_rsp(ST_OK, '0, 0, 1'b1);
				end
			end
			OP_DELETE: begin
				for (int i = 0; i < count; i++)
					if (hit < 0 && shadow_list[i] == value)
						hit = i;
				if (count == 0)
					push_rsp(ST_EMPTY, '0, 0, 1'b1);
				else if (hit < 0)
					push_rsp(ST_NOT_FOUND, '0, 0, 1'b1);
				else begin
					push_rsp(ST_OK, shadow_list[hit], hit + 1, 1'b1);
					shadow_list.delete(hit);
				end
			end
			default: begin
				if (count == 0)
					push_rsp(ST_EMPTY, '0, 0, 1'b1);
				else begin
					n = (count < READ_LIMIT) ? count : READ_LIMIT;
					for (int i = 0; i < n; i++)
						push_rsp(ST_OK, shadow_list[i], i + 1, i == n - 1);
				end
			end
		endcase
	endfunction

	// The command side is handled first, so a response that shows up at the
	// same edge as its command still finds its expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				predict_command(cmd.operation, cmd.value, cmd.position);
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("unexpected response transaction: status %0d value %0d index %0d last %0b",
						rsp.status, rsp.item_value, rsp.item_index, rsp.last);
					error_count++;
				end else begin
					oldest = expected_rsp_q.pop_front();
					if (rsp.status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, rsp.status);
						error_count++;
					end
					if (rsp.item_value !== oldest.item_value) begin
						$error("item_value: expected %0d, got %0d", oldest.item_value,
							rsp.item_value);
						error_count++;
					end
					if (rsp.item_index !== oldest.item_index) begin
						$error("item_index: expected %0d, got %0d", oldest.item_index,
							rsp.item_index);
						error_count++;
					end
					if (rsp.last !== oldest.last) begin
						$error("last: expected %0b, got %0b", oldest.last, rsp.last);
						error_count++;
					end
					results_checked++;
				end
			end
			pending = expected_rsp_q.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the ordered list engine with a directed opening, a phase that stalls
// the response side and then runs the list full, and random command mixes
// that lean toward filling, balancing and draining the list. Checking is done
// by list_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import bole_pkg::*;

	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
	localparam int PHASE_ITEMS  = 40;

	localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

	typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

	logic clk;
	logic arst_n;
	int   error_count;
	int   pending;
	int   results_checked;
	bit   hold_request;
	bit   gaps_off;
	int   sent_per_op[4];
	logic signed [DATA_W-1:0] value_pool[8];

	bole_cmd_if cmd ();
	bole_rsp_if rsp ();

	bounded_ordered_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	list_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.rsp             (rsp),
		.error_count     (error_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Run did not finish in time.");
		$display("TB_ERROR");
		$finish;
	end

	// Each call waits a random gap unless gaps_off is set, offers one transaction
	// and returns at the edge that accepts it, with valid still high.
	task automatic send_command(op_t op, logic signed [DATA_W-1:0] value,
			logic [POS_W-1:0] position);
		int gap;
		gap = gaps_off ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.operation <= op;
		cmd.value     <= value;
		cmd.position  <= position;
		do @(posedge clk); while (!cmd.ready);
		sent_per_op[int'(op)]++;
	endtask

	// Values mostly come from a small pool so that deletes find their keys.
	function automatic logic signed [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 60)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return POS_W'($urandom_range(0, CAPACITY + 1));
		if (r < 90)
			return POS_W'(1);
		return POS_W'($urandom_range(0, 255));
	endfunction

	function automatic op_t pick_op(mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  return (r < 35) ? OP_INS_HEAD : (r < 75) ? OP_INS_POS :
				(r < 90) ? OP_DELETE : OP_READ;
			MIX_DRAIN: return (r < 15) ? OP_INS_HEAD : (r < 30) ? OP_INS_POS :
				(r < 85) ? OP_DELETE : OP_READ;
			default:   return (r < 25) ? OP_INS_HEAD : (r < 50) ? OP_INS_POS :
				(r < 75) ? OP_DELETE : OP_READ;
		endcase
	endfunction

	// Response side: a random number of stalled cycles before each transaction
	// unless gaps_off is set, and one long hold-off when the stimulus asks for it.
	initial begin : receiver
		int gap;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			gap = gaps_off ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin : stimulus
		mix_t mix;
		arst_n        = 1'b0;
		hold_request  = 1'b0;
		gaps_off      = 1'b0;
		cmd.valid     <= 1'b0;
		cmd.operation <= OP_INS_HEAD;
		cmd.value     <= '0;
		cmd.position  <= '0;
		value_pool[0] = MAX_VAL;
		value_pool[1] = MIN_VAL;
		value_pool[2] = 0;
		value_pool[3] = -1;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, position edge cases, head and middle inserts, the first of
		// two equal keys, head and tail deletes, and back to empty.
		send_command(OP_READ, 0, 0);
		send_command(OP_DELETE, 5, 0);
		send_command(OP_INS_POS, 1, 0);
		send_command(OP_INS_POS, 2, 2);
		send_command(OP_INS_POS, MAX_VAL, 1);
		send_command(OP_INS_POS, MIN_VAL, 1);
		send_command(OP_INS_HEAD, -1, 0);
		send_command(OP_INS_POS, 0, 3);
		send_command(OP_INS_POS, 7, 5);
		send_command(OP_INS_POS, 0, 4);
		send_command(OP_INS_POS, 9, 255);
		send_command(OP_READ, 0, 0);
		send_command(OP_DELETE, 12345, 0);
		send_command(OP_DELETE, 0, 0);
		send_command(OP_DELETE, MIN_VAL, 0);
		send_command(OP_DELETE, MAX_VAL, 0);
		send_command(OP_READ, 0, 0);
		send_command(OP_DELETE, -1, 0);
		send_command(OP_DELETE, 0, 0);
		send_command(OP_READ, 0, 0);

		// The receiver holds off while inserts keep coming: the engine backs up,
		// the list runs full and both insert kinds are refused.
		hold_request = 1'b1;
		for (int i = 0; i < CAPACITY + 2; i++)
			send_command(OP_INS_HEAD, $urandom, 0);
		send_command(OP_INS_POS, pick_value(), 1);
		send_command(OP_READ, 0, 0);

		for (int phase = 0; phase < 6; phase++) begin
			mix      = mix_t'(phase % 3);
			gaps_off = (phase == 4);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_command(pick_op(mix), pick_value(), pick_position());
		end
		gaps_off = 1'b0;
		cmd.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d head inserts, %0d positional inserts, %0d deletes, %0d read-outs.",
			sent_per_op[int'(OP_INS_HEAD)], sent_per_op[int'(OP_INS_POS)],
			sent_per_op[int'(OP_DELETE)], sent_per_op[int'(OP_READ)]);
		$display("Checked %0d response transactions, including a full list and a long stall.",
			results_checked);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
